// File: rtl/i2cwp_pkg.sv
// Shared types, state codes and item classification for the I2C write phase generator.
`timescale 1ns / 1ps

package i2cwp_pkg;

  // Input item: address or data byte
  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } in_item_t;

  // Result item: one bus phase
  typedef struct packed {
    logic scl;
    logic sda;
    logic end_of_run;
  } out_item_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       stop;
  } cmd_t;

  // Item kind codes
  localparam logic KIND_ADDR = 1'b0;

  // Phase sequencer states
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_BITS,
    SEQ_ACK,
    SEQ_STOP
  } seq_state_t;

  // Each bus symbol spans three phases; a byte spans eight bits
  localparam logic [1:0] SUB_FIRST = 2'd0;
  localparam logic [1:0] SUB_MID   = 2'd1;
  localparam logic [1:0] SUB_LAST  = 2'd2;
  localparam logic [2:0] BIT_LAST  = 3'd7;

  // Turn an input item into a command: an address gets START and the write
  // bit appended, a data byte gets STOP when marked last
  function automatic cmd_t classify(input in_item_t it);
    cmd_t c;
    if (it.kind == KIND_ADDR) begin
      c.start = 1'b1;
      c.data  = {it.value[6:0], 1'b0};
      c.stop  = 1'b0;
    end else begin
      c.start = 1'b0;
      c.data  = it.value;
      c.stop  = it.last;
    end
    return c;
  endfunction

endpackage

// File: rtl/i2cwp_front.sv
// Front stage: accept input beats and register the classified command.
`timescale 1ns / 1ps

module i2cwp_front
  import i2cwp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t item,
  output logic     full,
  output logic     cmd_push,
  output cmd_t     cmd,
  input  logic     cmd_full
);

  logic cmd_valid;
  logic accept;
  logic drain;

  // Hand the held command onward when the queue has room
  assign drain    = cmd_valid && !cmd_full;
  assign full     = cmd_valid && cmd_full;
  assign accept   = push && !full;
  assign cmd_push = cmd_valid;

  // Hold the valid flag until the queue takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (drain) begin
      cmd_valid <= 1'b0;
    end
  end

  // Classify on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= classify(item);
    end
  end

endmodule

// File: rtl/i2cwp_cmd_queue.sv
// Short command queue between the front and the phase sequencer.
`timescale 1ns / 1ps

module i2cwp_cmd_queue
  import i2cwp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = slots[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_cmd;
    end
  end

endmodule

// File: rtl/i2cwp_back.sv
// Back stage: step through bus phases of each command into the result register.
`timescale 1ns / 1ps

module i2cwp_back
  import i2cwp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  output out_item_t phase,
  output logic      empty,
  input  logic      pop
);

  seq_state_t state, state_next;
  logic [1:0] sub, sub_next;
  logic [2:0] bitcnt, bitcnt_next;
  logic [7:0] shreg, shreg_next;
  logic       stop, stop_next;
  logic       ovalid, ovalid_next;
  out_item_t  phase_next;
  out_item_t  cur;
  logic       advance;
  logic       take;

  assign empty   = !ovalid;
  assign advance = !ovalid || pop;

  // Decode the current phase levels
  always_comb begin
    cur = '0;
    unique case (state)
      SEQ_IDLE: begin
        cur = '0;
      end
      SEQ_START: begin
        cur.scl = (sub != SUB_LAST);
        cur.sda = (sub == SUB_FIRST);
      end
      SEQ_BITS: begin
        cur.scl = (sub == SUB_MID);
        cur.sda = shreg[7];
      end
      SEQ_ACK: begin
        cur.scl        = (sub == SUB_MID);
        cur.sda        = 1'b1;
        cur.end_of_run = (sub == SUB_LAST) && !stop;
      end
      SEQ_STOP: begin
        cur.scl        = (sub != SUB_FIRST);
        cur.sda        = (sub == SUB_LAST);
        cur.end_of_run = (sub == SUB_LAST);
      end
      default: begin
        cur = '0;
      end
    endcase
  end

  // Next state: emit a phase when the result register frees, load on item end
  always_comb begin
    state_next  = state;
    sub_next    = sub;
    bitcnt_next = bitcnt;
    shreg_next  = shreg;
    stop_next   = stop;
    ovalid_next = ovalid && !pop;
    phase_next  = phase;
    take        = 1'b0;

    if (state == SEQ_IDLE) begin
      take = !cmd_empty;
    end else if (advance) begin
      ovalid_next = 1'b1;
      phase_next  = cur;
      if (sub != SUB_LAST) begin
        sub_next = sub + 1'b1;
      end else begin
        sub_next = SUB_FIRST;
        unique case (state)
          SEQ_START: begin
            state_next = SEQ_BITS;
          end
          SEQ_BITS: begin
            shreg_next  = {shreg[6:0], 1'b0};
            bitcnt_next = bitcnt + 1'b1;
            if (bitcnt == BIT_LAST) begin
              state_next = SEQ_ACK;
            end
          end
          SEQ_ACK: begin
            if (stop) begin
              state_next = SEQ_STOP;
            end else begin
              state_next = SEQ_IDLE;
              take       = !cmd_empty;
            end
          end
          SEQ_STOP: begin
            state_next = SEQ_IDLE;
            take       = !cmd_empty;
          end
          default: begin
            state_next = SEQ_IDLE;
          end
        endcase
      end
    end

    // Load the next command straight behind the finished one
    if (take) begin
      state_next  = cmd.start ? SEQ_START : SEQ_BITS;
      sub_next    = SUB_FIRST;
      bitcnt_next = '0;
      shreg_next  = cmd.data;
      stop_next   = cmd.stop;
    end
  end

  assign cmd_pop = take;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SEQ_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sub    <= sub_next;
    bitcnt <= bitcnt_next;
    shreg  <= shreg_next;
    stop   <= stop_next;
    phase  <= phase_next;
  end

endmodule

// File: rtl/i2c_master_write_phase_generator_core.sv
// Top level of the I2C write phase generator: front, command queue, sequencer.
//
//   channel  direction  beat        handshake
//   item     in         in_item_t   push / full   (taken on push && !full)
//   phase    out        out_item_t  empty / pop   (taken on pop && !empty)
//
// Phases: 30 for an address item, 27 for a data item, 30 with STOP; one per
// cycle while pop keeps up, with the next command loaded at the edge that
// registers the last phase of the previous one, so items run without a gap.
// Each item passes the front register and queue before the sequencer takes it.
// With pop low the sequencer holds; the front register and QDEPTH-entry queue
// fill, then full rises. Reset (rst, synchronous) empties every stage.
`timescale 1ns / 1ps

module i2c_master_write_phase_generator_core
  import i2cwp_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_item_t  item,
  output logic      full,
  output out_item_t phase,
  output logic      empty,
  input  logic      pop
);

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic front_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  i2cwp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_push (front_push),
    .cmd      (front_cmd),
    .cmd_full (q_full)
  );

  i2cwp_cmd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (front_push),
    .wr_cmd (front_cmd),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_cmd (q_cmd),
    .empty  (q_empty)
  );

  i2cwp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .phase     (phase),
    .empty     (empty),
    .pop       (pop)
  );

`ifndef SYNTH
  // Queue cannot be full and empty at once
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("command queue full and empty together");

  // Input side opens after reset
  a_reset_open: assert property (@(posedge clk)
    rst |=> !full)
    else $error("full set after reset");

  // The final phase of any item leaves SDA released
  a_end_sda: assert property (@(posedge clk) disable iff (rst)
    (!empty && phase.end_of_run) |-> phase.sda)
    else $error("end of run with SDA low");

  // The sequencer only pulls from a non-empty queue
  a_pop_guard: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty command queue");
`endif

endmodule

// File: tb/i2cwp_phase_monitor.sv
// Watches both channels of the I2C write phase generator and scores each phase.
`timescale 1ns / 1ps

module i2cwp_phase_monitor
  import i2cwp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  item,
  input  out_item_t phase,
  input  logic      empty,
  input  logic      pop,
  output int        fail_count,
  output int        pending,
  output int        items_taken,
  output int        phases_checked
);

  out_item_t bus_phase_q[$];
  int        errs;
  int        n_items;
  int        n_phases;

  initial begin
    errs     = 0;
    n_items  = 0;
    n_phases = 0;
  end

  // Append one expected bus phase with end_of_run clear
  task automatic add_phase(input logic scl_lv, input logic sda_lv);
    out_item_t ph;
    ph.scl        = scl_lv;
    ph.sda        = sda_lv;
    ph.end_of_run = 1'b0;
    bus_phase_q.push_back(ph);
  endtask

  // Expand one accepted item into its full list of bus phases
  task automatic expand_item(input in_item_t it);
    logic [7:0] tx_byte;
    out_item_t  tail;
    int         k;
    if (it.kind == KIND_ADDR) begin
      // START, then the address moved up one place with the write bit clear
      add_phase(1'b1, 1'b1);
      add_phase(1'b1, 1'b0);
      add_phase(1'b0, 1'b0);
      tx_byte = {it.value[6:0], 1'b0};
    end else begin
      tx_byte = it.value;
    end
    // MSB first: set SDA, raise SCL, lower SCL
    for (k = 7; k >= 0; k--) begin
      add_phase(1'b0, tx_byte[k]);
      add_phase(1'b1, tx_byte[k]);
      add_phase(1'b0, tx_byte[k]);
    end
    // Acknowledge clock with SDA released
    add_phase(1'b0, 1'b1);
    add_phase(1'b1, 1'b1);
    add_phase(1'b0, 1'b1);
    // STOP only after a data byte marked last
    if (it.kind != KIND_ADDR && it.last) begin
      add_phase(1'b0, 1'b0);
      add_phase(1'b1, 1'b0);
      add_phase(1'b1, 1'b1);
    end
    tail = bus_phase_q.pop_back();
    tail.end_of_run = 1'b1;
    bus_phase_q.push_back(tail);
  endtask

  // Score output beats first, then expand any input beat of the same edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      bus_phase_q.delete();
    end else begin
      if (pop && !empty) begin
        n_phases++;
        if (bus_phase_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("[%0t] unexpected phase scl=%b sda=%b end_of_run=%b",
                     $realtime, phase.scl, phase.sda, phase.end_of_run);
        end else begin
          want = bus_phase_q.pop_front();
          if (phase.scl !== want.scl || phase.sda !== want.sda ||
              phase.end_of_run !== want.end_of_run) begin
            errs++;
            if (errs <= 10)
              $display("[%0t] phase %0d: expected scl=%b sda=%b eor=%b, got scl=%b sda=%b eor=%b",
                       $realtime, n_phases, want.scl, want.sda, want.end_of_run,
                       phase.scl, phase.sda, phase.end_of_run);
          end
        end
      end
      if (push && !full) begin
        n_items++;
        expand_item(item);
      end
    end
    // Publish counts after the edge so readers never race the update
    fail_count     <= errs;
    pending        <= bus_phase_q.size();
    items_taken    <= n_items;
    phases_checked <= n_phases;
  end

endmodule

// File: tb/tb_i2c_master_write_phase_generator_core.sv
// Testbench top: clock, reset, item stimulus, output pacing and the final verdict.
`timescale 1ns / 1ps

module tb_i2c_master_write_phase_generator_core;
  import i2cwp_pkg::*;

  localparam logic KIND_DATA      = ~KIND_ADDR;
  localparam int   ITEMS_PER_MIX  = 130;
  localparam int   HOLD_CYCLES    = 400;
  localparam int   DRAIN_CYCLES   = 60;
  localparam int   CYCLE_LIMIT    = 400000;

  logic      clk;
  logic      rst  = 1'b1;
  logic      push = 1'b0;
  logic      pop  = 1'b0;
  in_item_t  item = '0;
  logic      full;
  logic      empty;
  out_item_t phase;

  int fail_count;
  int pending;
  int items_taken;
  int phases_checked;

  int send_idle_pct = 16;
  int recv_idle_pct = 58;
  bit hold_req      = 1'b0;
  int hold_cnt      = 0;
  int cycles        = 0;
  int n_sent        = 0;
  int n_addr        = 0;
  int n_stop        = 0;

  i2c_master_write_phase_generator_core dut (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .item (item),
    .full (full),
    .phase(phase),
    .empty(empty),
    .pop  (pop)
  );

  i2cwp_phase_monitor mon (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .phase         (phase),
    .empty         (empty),
    .pop           (pop),
    .fail_count    (fail_count),
    .pending       (pending),
    .items_taken   (items_taken),
    .phases_checked(phases_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("i2c_master_write_phase_generator_core: mismatch");
        $finish;
      end
    end
  end

  // Pace the phase output; hold pop off for a long stretch on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) begin
          hold_req = 1'b0;
          hold_cnt = 0;
        end
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic in_item_t mk_item(input logic kind, input logic [7:0] value,
                                       input logic last);
    in_item_t it;
    it.kind  = kind;
    it.value = value;
    it.last  = last;
    return it;
  endfunction

  // Offer one item, with random idle cycles ahead of it, and hold until taken
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    n_sent++;
    if (it.kind == KIND_ADDR) n_addr++;
    else if (it.last) n_stop++;
  endtask

  // Address, a few data bytes, usually closed by STOP; sometimes left open
  task automatic send_transaction();
    int n_data;
    int d;
    bit close_it;
    n_data   = $urandom_range(1, 5);
    close_it = ($urandom_range(7) != 0);
    send_item(mk_item(KIND_ADDR, 8'($urandom_range(255)), 1'($urandom_range(1))));
    for (d = 0; d < n_data; d++)
      send_item(mk_item(KIND_DATA, 8'($urandom_range(255)),
                        close_it && (d == n_data - 1)));
  endtask

  // Mostly well-formed transactions, with some raw random items mixed in
  task automatic run_mix(input int target);
    int stop_at;
    stop_at = n_sent + target;
    while (n_sent < stop_at) begin
      if ($urandom_range(99) < 80)
        send_transaction();
      else
        send_item(mk_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                          1'($urandom_range(1))));
    end
  endtask

  initial begin
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: data with no START, address extremes, lost address MSB,
    // last on an address, repeated START, data byte extremes
    send_item(mk_item(KIND_DATA, 8'hC3, 1'b0));
    send_item(mk_item(KIND_ADDR, 8'h00, 1'b0));
    send_item(mk_item(KIND_DATA, 8'h00, 1'b0));
    send_item(mk_item(KIND_DATA, 8'hFF, 1'b1));
    send_item(mk_item(KIND_ADDR, 8'h7F, 1'b0));
    send_item(mk_item(KIND_ADDR, 8'h80, 1'b1));
    send_item(mk_item(KIND_ADDR, 8'hFF, 1'b0));
    send_item(mk_item(KIND_DATA, 8'hA5, 1'b0));
    send_item(mk_item(KIND_DATA, 8'h5A, 1'b1));
    send_item(mk_item(KIND_DATA, 8'h01, 1'b1));
    send_item(mk_item(KIND_ADDR, 8'h2A, 1'b0));
    send_item(mk_item(KIND_ADDR, 8'h55, 1'b0));
    send_item(mk_item(KIND_DATA, 8'h80, 1'b1));

    // Random: slow receiver, then slow sender, then full rate with a long stall
    run_mix(ITEMS_PER_MIX);
    send_idle_pct = 58;
    recv_idle_pct = 16;
    run_mix(ITEMS_PER_MIX);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    run_mix(ITEMS_PER_MIX);
    push <= 1'b0;

    // Drain: let the published count catch up, then wait for it to clear
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d addresses, %0d closed by STOP), scored %0d bus phases.",
             items_taken, n_addr, n_stop, phases_checked);
    $display("Covered three idle mixes and a %0d-cycle output stall with the input backed up.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("i2c_master_write_phase_generator_core: match");
    end else begin
      $display("failures: %0d, phases still expected: %0d", fail_count, pending);
      $display("i2c_master_write_phase_generator_core: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/i2cwp_pkg.sv
rtl/i2cwp_front.sv
rtl/i2cwp_cmd_queue.sv
rtl/i2cwp_back.sv
rtl/i2c_master_write_phase_generator_core.sv
tb/i2cwp_phase_monitor.sv
tb/tb_i2c_master_write_phase_generator_core.sv
